[rtl/core/kagf_pkg.sv]
`default_nettype none
package kagf_pkg;

    localparam int unsigned MUL_A_W   = 51;
    localparam int unsigned MUL_B_W   = 26;
    localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
    localparam int unsigned MUL_LO_W  = 25;
    localparam int unsigned DIV_STEPS = 24;

    typedef logic signed [55:0]        t_wide;
    typedef logic signed [47:0]        t_cov;
    typedef logic signed [31:0]        t_ang;
    typedef logic signed [32:0]        t_innov;
    typedef logic signed [48:0]        t_innov_var;
    typedef logic signed [25:0]        t_gain;
    typedef logic signed [MUL_A_W-1:0] t_mul_a;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic [1:0]                t_cfg_idx;

    localparam t_cfg_idx REG_ANGLE_NOISE = 2'd0;
    localparam t_cfg_idx REG_BIAS_NOISE  = 2'd1;
    localparam t_cfg_idx REG_MEAS_NOISE  = 2'd2;

    localparam logic [23:0] ANGLE_NOISE_RST = 24'd167772;
    localparam logic [23:0] BIAS_NOISE_RST  = 24'd5033;
    localparam logic [23:0] MEAS_NOISE_RST  = 24'd167772;

    localparam t_wide ANG_MAX = 56'sd2147483647;
    localparam t_wide ANG_MIN = -56'sd2147483648;
    localparam t_wide COV_MAX = 56'sd140737488355327;
    localparam t_wide COV_MIN = -56'sd140737488355328;
    localparam t_gain GAIN_ONE = 26'sd16777216;

    function automatic t_ang sat_ang(input t_wide v);
        t_wide c;
        c = (v > ANG_MAX) ? ANG_MAX : ((v < ANG_MIN) ? ANG_MIN : v);
        return c[31:0];
    endfunction

    function automatic t_cov sat_cov(input t_wide v);
        t_wide c;
        c = (v > COV_MAX) ? COV_MAX : ((v < COV_MIN) ? COV_MIN : v);
        return c[47:0];
    endfunction

    // round half up of a q24 product
    function automatic t_wide round24(input t_prod p);
        t_prod t;
        t = p + t_prod'(77'sd8388608);
        return t_wide'($signed(t[PROD_W-1:24]));
    endfunction

endpackage
`default_nettype wire

[rtl/core/kalman_angle_gyro_fusion.sv]
// ten products go through the shared 51x26 multiplier, formed from two 26x26 partial products
// each gain comes from the 1-bit-per-cycle divider, which ends early when clamped or on a zero divisor
// a new word is accepted only in idle, input not ready while busy
// synchronous active-low reset clears state, estimates and covariance, and loads the noise defaults
`default_nettype none
module kalman_angle_gyro_fusion (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic signed [31:0]  i_measured_angle,
    input  wire logic signed [31:0]  i_gyro_rate,
    input  wire logic [23:0]         i_time_step,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [31:0]       o_angle_estimate,
    output logic signed [31:0]       o_bias_estimate,
    input  wire logic                i_cfg_we,
    input  wire kagf_pkg::t_cfg_idx  i_cfg_index,
    input  wire logic [23:0]         i_cfg_data
);
    import kagf_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_ANG  = 14'b00000000000010,
        S_QG   = 14'b00000000000100,
        S_P00  = 14'b00000000001000,
        S_P01  = 14'b00000000010000,
        S_K0   = 14'b00000000100000,
        S_K1   = 14'b00000001000000,
        S_AC   = 14'b00000010000000,
        S_BC   = 14'b00000100000000,
        S_C00  = 14'b00001000000000,
        S_C01  = 14'b00010000000000,
        S_C10  = 14'b00100000000000,
        S_C11  = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [23:0] r_qa, r_qb, r_rn;
    t_ang        r_meas;
    logic [23:0] r_dt;
    t_ang        r_angle, r_bias;
    t_cov        r_caa, r_cab, r_cba, r_cbb;
    t_cov        r_p00, r_p01, r_p10, r_p11;
    logic [32:0] r_qg;
    t_innov      r_y;
    t_innov_var  r_s;
    t_gain       r_k0, r_k1;
    logic        r_out_valid;
    t_ang        r_out_angle, r_out_bias;

    logic       w_accept, w_out_free;
    logic       w_mul_start, w_mul_done;
    t_mul_a     w_ma;
    t_mul_b     w_mb;
    t_prod      w_prod;
    t_wide      w_rnd;
    logic       w_div_start, w_div_done;
    t_cov       w_dnum;
    t_innov_var w_dden;
    t_innov_var w_s_new;
    t_gain      w_gain;
    logic [48:0] w_qg_sum;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_rnd      = round24(w_prod);
    assign w_qg_sum   = w_prod[48:0] + 49'd32768;
    assign w_s_new    = t_innov_var'(t_wide'(r_p00) + t_wide'({r_rn, 8'h00}));

    kagf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    kagf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_div_done),
        .o_gain  (w_gain)
    );

    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_ma        = '0;
        w_mb        = '0;
        w_div_start = 1'b0;
        w_dnum      = r_p10;
        w_dden      = r_s;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state     = S_ANG;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'(t_wide'(i_gyro_rate) - t_wide'(r_bias));
                    w_mb = t_mul_b'({1'b0, i_time_step});
                end
            end
            S_ANG: begin
                if (w_mul_done) begin
                    n_state     = S_QG;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'({1'b0, r_qb});
                    w_mb = t_mul_b'({1'b0, r_dt});
                end
            end
            S_QG: begin
                if (w_mul_done) begin
                    n_state     = S_P00;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'(t_wide'({r_qa, 8'h00}) - t_wide'(r_cab)
                                    - t_wide'(r_cba));
                    w_mb = t_mul_b'({1'b0, r_dt});
                end
            end
            S_P00: begin
                if (w_mul_done) begin
                    n_state     = S_P01;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'(r_cbb);
                    w_mb = t_mul_b'({1'b0, r_dt});
                end
            end
            S_P01: begin
                if (w_mul_done) begin
                    n_state     = S_K0;
                    w_div_start = 1'b1;
                    w_dnum      = r_p00;
                    w_dden      = w_s_new;
                end
            end
            S_K0: begin
                if (w_div_done) begin
                    n_state     = S_K1;
                    w_div_start = 1'b1;
                end
            end
            S_K1: begin
                if (w_div_done) begin
                    n_state     = S_AC;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'(r_y);
                    w_mb = r_k0;
                end
            end
            S_AC: begin
                if (w_mul_done) begin
                    n_state     = S_BC;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'(r_y);
                    w_mb = r_k1;
                end
            end
            S_BC: begin
                if (w_mul_done) begin
                    n_state     = S_C00;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'(r_p00);
                    w_mb = r_k0;
                end
            end
            S_C00: begin
                if (w_mul_done) begin
                    n_state     = S_C01;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'(r_p01);
                    w_mb = r_k0;
                end
            end
            S_C01: begin
                if (w_mul_done) begin
                    n_state     = S_C10;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'(r_p00);
                    w_mb = r_k1;
                end
            end
            S_C10: begin
                if (w_mul_done) begin
                    n_state     = S_C11;
                    w_mul_start = 1'b1;
                    w_ma = t_mul_a'(r_p01);
                    w_mb = r_k1;
                end
            end
            S_C11: begin
                if (w_mul_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_qa        <= ANGLE_NOISE_RST;
            r_qb        <= BIAS_NOISE_RST;
            r_rn        <= MEAS_NOISE_RST;
            r_angle     <= '0;
            r_bias      <= '0;
            r_caa       <= '0;
            r_cab       <= '0;
            r_cba       <= '0;
            r_cbb       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ANGLE_NOISE: r_qa <= i_cfg_data;
                    REG_BIAS_NOISE:  r_qb <= i_cfg_data;
                    REG_MEAS_NOISE:  r_rn <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_mul_done) begin
                unique case (r_state)
                    S_ANG: r_angle <= sat_ang(t_wide'(r_angle) + w_rnd);
                    S_AC:  r_angle <= sat_ang(t_wide'(r_angle) + w_rnd);
                    S_BC:  r_bias  <= sat_ang(t_wide'(r_bias) + w_rnd);
                    S_C00: r_caa   <= sat_cov(t_wide'(r_p00) - w_rnd);
                    S_C01: r_cab   <= sat_cov(t_wide'(r_p01) - w_rnd);
                    S_C10: r_cba   <= sat_cov(t_wide'(r_p10) - w_rnd);
                    S_C11: r_cbb   <= sat_cov(t_wide'(r_p11) - w_rnd);
                    default: ;
                endcase
            end
        end
    end

    // working values, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_meas <= i_measured_angle;
            r_dt   <= i_time_step;
        end
        if (w_mul_done) begin
            case (r_state)
                S_QG:  r_qg  <= w_qg_sum[48:16];
                S_P00: r_p00 <= sat_cov(t_wide'(r_caa) + w_rnd);
                S_P01: begin
                    r_p01 <= sat_cov(t_wide'(r_cab) - w_rnd);
                    r_p10 <= sat_cov(t_wide'(r_cba) - w_rnd);
                    r_p11 <= sat_cov(t_wide'(r_cbb) + t_wide'({1'b0, r_qg}));
                    r_y   <= t_innov'(t_wide'(r_meas) - t_wide'(r_angle));
                    r_s   <= w_s_new;
                end
                default: ;
            endcase
        end
        if (w_div_done) begin
            case (r_state)
                S_K0: r_k0 <= w_gain;
                S_K1: r_k1 <= w_gain;
                default: ;
            endcase
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_angle <= r_angle;
            r_out_bias  <= r_bias;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_angle_estimate = r_out_angle;
    assign o_bias_estimate  = r_out_bias;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_div_done))
        else $error("multiplier and divider finished together");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_mul_done && !w_div_done))
        else $error("arithmetic unit finished while idle");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (w_gain <= GAIN_ONE && w_gain >= -GAIN_ONE))
        else $error("gain outside unit range");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !w_out_free) |=> (r_state == S_OUT))
        else $error("result dropped while output busy");

endmodule
`default_nettype wire

[rtl/core/kagf_mul.sv]
`default_nettype none
module kagf_mul (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire kagf_pkg::t_mul_a i_a,
    input  wire kagf_pkg::t_mul_b i_b,
    output logic                 o_done,
    output kagf_pkg::t_prod      o_prod
);
    import kagf_pkg::*;

    logic [1:0]                  r_phase;
    logic                        r_done;
    t_mul_a                      r_a;
    t_mul_b                      r_b;
    logic signed [MUL_B_W*2-1:0] r_pp;
    t_prod                       r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= !i_start && (r_phase == 2'd3);
            if (i_start) begin
                r_phase <= 2'd1;
            end else if (r_phase != 2'd0) begin
                r_phase <= r_phase + 2'd1;
            end
        end
    end

    // low partial product, then high partial product, then combine
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        case (r_phase)
            2'd1: r_pp <= $signed({1'b0, r_a[MUL_LO_W-1:0]}) * r_b;
            2'd2: begin
                r_acc <= t_prod'(r_pp);
                r_pp  <= $signed(r_a[MUL_A_W-1:MUL_LO_W]) * r_b;
            end
            2'd3: r_acc <= r_acc + (t_prod'(r_pp) <<< MUL_LO_W);
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

[rtl/core/kagf_div.sv]
`default_nettype none
module kagf_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire kagf_pkg::t_cov      i_num,
    input  wire kagf_pkg::t_innov_var i_den,
    output logic                     o_done,
    output kagf_pkg::t_gain          o_gain
);
    import kagf_pkg::*;

    logic        r_busy;
    logic        r_first;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic [47:0] r_num;
    logic [48:0] r_den;
    logic [49:0] r_rem;
    logic [23:0] r_q;
    t_gain       r_gain;

    logic [49:0] w_shift;
    logic        w_ge;
    logic [23:0] w_q_nx;
    t_gain       w_mag;
    logic        w_fin;

    assign w_shift = {r_rem[48:0], 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_q_nx  = {r_q[22:0], w_ge};
    assign w_mag   = t_gain'({2'b00, w_q_nx});
    assign w_fin   = r_busy && (r_first ? (r_den == '0 || {1'b0, r_num} >= r_den)
                                        : (r_cnt == 5'(DIV_STEPS - 1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && w_fin;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_first <= 1'b1;
            r_neg   <= i_num[47] != i_den[48];
            r_num   <= i_num[47] ? (~i_num + 48'd1) : i_num;
            r_den   <= i_den[48] ? (~i_den + 49'd1) : i_den;
        end else if (r_busy) begin
            if (r_first) begin
                r_first <= 1'b0;
                r_rem   <= {2'b00, r_num};
                r_q     <= '0;
                r_cnt   <= '0;
                if (r_den == '0) begin
                    r_gain <= '0;
                end else if ({1'b0, r_num} >= r_den) begin
                    r_gain <= r_neg ? -GAIN_ONE : GAIN_ONE;
                end
            end else begin
                r_rem  <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
                r_q    <= w_q_nx;
                r_cnt  <= r_cnt + 5'd1;
                r_gain <= r_neg ? -w_mag : w_mag;
            end
        end
    end

    assign o_done = r_done;
    assign o_gain = r_gain;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kagf_pkg::*;

    localparam longint A_HI = 64'sd2147483647;
    localparam longint A_LO = -64'sd2147483648;
    localparam longint P_HI = (64'sd1 <<< 47) - 1;
    localparam longint P_LO = -(64'sd1 <<< 47);
    localparam longint Q24 = 64'sd1 <<< 24;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } t_estimate;

    typedef struct packed {
        logic signed [31:0] meas;
        logic signed [31:0] rate;
        logic [23:0]        dt;
        logic               fixed;
        logic signed [31:0] x_angle;
        logic signed [31:0] x_bias;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [31:0] i_measured_angle = '0;
    logic signed [31:0] i_gyro_rate = '0;
    logic [23:0] i_time_step = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [31:0] o_angle_estimate;
    logic signed [31:0] o_bias_estimate;
    logic i_cfg_we = 1'b0;
    t_cfg_idx i_cfg_index = REG_ANGLE_NOISE;
    logic [23:0] i_cfg_data = '0;

    kalman_angle_gyro_fusion i_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // filter state mirror
    longint f_ang, f_bias, f_p00, f_p01, f_p10, f_p11;
    longint n_qa, n_qg, n_r;
    t_estimate pending_estimates[$];
    int errors = 0;
    int mismatches = 0;
    bit no_idle = 0;

    function automatic longint floor24(longint v);
        return v >>> 24;
    endfunction

    function automatic longint mulr(longint a, longint b);
        longint hi, lo;
        hi = floor24(a);
        lo = a - hi * Q24;
        return hi * b + floor24(lo * b + (64'sd1 <<< 23));
    endfunction

    function automatic longint lim(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint kgain(longint num, longint den);
        longint unsigned a, d, q, r;
        a = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = 0;
        r = a;
        if (d == 0) return 0;
        if (a >= d) begin
            q = Q24;
        end else begin
            for (int i = 0; i < 24; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 1;
                end
            end
        end
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_estimate filter_step(logic signed [31:0] meas,
                                              logic signed [31:0] rate,
                                              logic [23:0] dt_in);
        longint dt, qa, r, qgdt, p00, p01, p10, p11, y, s, k0, k1;
        t_estimate e;
        dt = longint'(dt_in);
        qa = n_qa <<< 8;
        r = n_r <<< 8;
        f_ang = lim(f_ang + mulr(longint'(rate) - f_bias, dt), A_LO, A_HI);
        qgdt = (n_qg * dt + 64'h8000) >>> 16;
        p00 = lim(f_p00 + mulr(qa - f_p01 - f_p10, dt), P_LO, P_HI);
        p01 = lim(f_p01 - mulr(f_p11, dt), P_LO, P_HI);
        p10 = lim(f_p10 - mulr(f_p11, dt), P_LO, P_HI);
        p11 = lim(f_p11 + qgdt, P_LO, P_HI);
        y = longint'(meas) - f_ang;
        s = p00 + r;
        k0 = kgain(p00, s);
        k1 = kgain(p10, s);
        f_ang = lim(f_ang + mulr(y, k0), A_LO, A_HI);
        f_bias = lim(f_bias + mulr(y, k1), A_LO, A_HI);
        f_p00 = lim(p00 - mulr(p00, k0), P_LO, P_HI);
        f_p01 = lim(p01 - mulr(p01, k0), P_LO, P_HI);
        f_p10 = lim(p10 - mulr(p00, k1), P_LO, P_HI);
        f_p11 = lim(p11 - mulr(p01, k1), P_LO, P_HI);
        e.angle = f_ang[31:0];
        e.bias = f_bias[31:0];
        return e;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ANGLE_NOISE) n_qa = longint'(val);
        else if (idx == REG_BIAS_NOISE) n_qg = longint'(val);
        else if (idx == REG_MEAS_NOISE) n_r = longint'(val);
    endtask

    task automatic send_word(logic signed [31:0] meas, logic signed [31:0] rate,
                             logic [23:0] dt);
        if (!no_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_measured_angle <= meas;
        i_gyro_rate <= rate;
        i_time_step <= dt;
        do @(posedge i_clk); while (!o_in_ready);
        pending_estimates.push_back(filter_step(meas, rate, dt));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // receiver side with random stall bursts
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                t_estimate got, want;
                got.angle = o_angle_estimate;
                got.bias = o_bias_estimate;
                if (pending_estimates.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected word %h", got);
                end else begin
                    want = pending_estimates.pop_front();
                    if (got.angle !== want.angle || got.bias !== want.bias) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch angle exp %h got %h bias exp %h got %h",
                                     want.angle, got.angle, want.bias, got.bias);
                    end
                end
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 3) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic directed_table();
        t_row rows[$];
        t_row rw;
        t_estimate e;
        // from reset, dt zero and measurement zero keep everything at zero
        rows.push_back('{32'sd0, 32'sd0, 24'd0, 1'b1, 32'sd0, 32'sd0});
        // zero dt leaves the angle unchanged, p00 zero gives zero gain
        rows.push_back('{32'sd0, 32'sd65536, 24'd0, 1'b1, 32'sd0, 32'sd0});
        rows.push_back('{32'h7fffffff, 32'h7fffffff, 24'hffffff, 1'b0, 0, 0});
        rows.push_back('{32'h80000000, 32'h80000000, 24'hffffff, 1'b0, 0, 0});
        rows.push_back('{32'h7fffffff, 32'h80000000, 24'd1, 1'b0, 0, 0});
        rows.push_back('{32'h80000000, 32'h7fffffff, 24'h800000, 1'b0, 0, 0});
        rows.push_back('{32'sd0, 32'sd0, 24'd0, 1'b0, 0, 0});
        rows.push_back('{32'h00010000, 32'hffff0000, 24'd16777, 1'b0, 0, 0});
        rows.push_back('{32'hffffffff, 32'h00000001, 24'h5a5a5a, 1'b0, 0, 0});
        rows.push_back('{32'h55555555, 32'haaaaaaaa, 24'ha5a5a5, 1'b0, 0, 0});
        rows.push_back('{32'haaaaaaaa, 32'h55555555, 24'h5a5a5a, 1'b0, 0, 0});
        foreach (rows[i]) begin
            rw = rows[i];
            send_word(rw.meas, rw.rate, rw.dt);
            if (rw.fixed) begin
                e = pending_estimates[$];
                if (e.angle !== rw.x_angle || e.bias !== rw.x_bias) begin
                    errors++;
                    $display("table row %0d model %h table %h", i, e,
                             {rw.x_angle, rw.x_bias});
                end
            end
        end
    endtask

    function automatic logic signed [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $signed(32'($urandom_range(0, 'h1ffffff))) - 32'sh1000000;
        endcase
    endfunction

    function automatic logic [23:0] pick24();
        case ($urandom_range(0, 5))
            0: return 24'hffffff;
            1: return 24'd0;
            2: return 24'($urandom);
            default: return 24'($urandom_range(1000, 400000));
        endcase
    endfunction

    task automatic run_phase(int n);
        logic signed [31:0] truth;
        truth = $urandom_range(0, 'h3fffff) - 'h200000;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) != 0)
                send_word(truth + ($urandom_range(0, 'h3ffff) - 'h20000),
                          $urandom_range(0, 'h7ffff) - 'h40000,
                          24'($urandom_range(10000, 300000)));
            else
                send_word(pick32(), pick32(), pick24());
        end
    endtask

    initial begin
        f_ang = 0; f_bias = 0; f_p00 = 0; f_p01 = 0; f_p10 = 0; f_p11 = 0;
        n_qa = longint'(ANGLE_NOISE_RST);
        n_qg = longint'(BIAS_NOISE_RST);
        n_r = longint'(MEAS_NOISE_RST);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_table();
        wait_idle();
        write_reg(REG_UNUSED, 24'h123456);
        write_reg(REG_MEAS_NOISE, 24'd0);
        write_reg(REG_ANGLE_NOISE, 24'd0);
        write_reg(REG_BIAS_NOISE, 24'd0);
        send_word(32'sd0, 32'sd0, 24'd0);
        send_word(32'sd100000, 32'sd5000, 24'd50000);
        run_phase(200);
        wait_idle();
        write_reg(REG_ANGLE_NOISE, 24'hffffff);
        write_reg(REG_BIAS_NOISE, 24'hffffff);
        write_reg(REG_MEAS_NOISE, 24'hffffff);
        run_phase(300);
        wait_idle();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_ANGLE_NOISE, 24'($urandom));
            write_reg(REG_BIAS_NOISE, 24'($urandom_range(0, 20000)));
            write_reg(REG_MEAS_NOISE, 24'($urandom));
            run_phase(220);
            wait_idle();
        end
        write_reg(REG_ANGLE_NOISE, ANGLE_NOISE_RST);
        write_reg(REG_BIAS_NOISE, BIAS_NOISE_RST);
        write_reg(REG_MEAS_NOISE, MEAS_NOISE_RST);
        run_phase(130);
        no_idle = 1;
        run_phase(120);
        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
